// ===== src/exlex_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Expression lexer package
// Shared widths, character codes, token and error codes, and the result and
// job records that travel from the scanner through the queue to the output.
// ----------------------------------------------------------------------------
package exlex_pkg;

   // Bounds on the string and on a single lexeme.
   localparam int unsigned MAX_STRING_LEN = 65535;
   localparam int unsigned MAX_LEXEME_LEN = 255;

   // Field widths.
   localparam int unsigned CHAR_W = 8;
   localparam int unsigned POS_W  = 16;
   localparam int unsigned LEN_W  = 8;

   // Depth of the job queue between the scanner and the output stage.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

   // Character codes.
   localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;
   localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;
   localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_EXP   = 8'h45;
   localparam logic [CHAR_W-1:0] CH_LOW_A = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LOW_E = 8'h65;
   localparam logic [CHAR_W-1:0] CH_LOW_I = 8'h69;
   localparam logic [CHAR_W-1:0] CH_LOW_P = 8'h70;
   localparam logic [CHAR_W-1:0] CH_LOW_Z = 8'h7A;

   // Scanner phases.
   typedef enum logic [3:0] {
      PH_IDLE = 4'd0,
      PH_INT  = 4'd1,
      PH_DOT  = 4'd2,
      PH_FRAC = 4'd3,
      PH_EXPE = 4'd4,
      PH_EXPS = 4'd5,
      PH_EXP  = 4'd6,
      PH_WORD = 4'd7,
      PH_SKIP = 4'd8
   } phase_type;

   typedef enum logic [3:0] {
      TK_NUMBER   = 4'd0,
      TK_PLUS     = 4'd1,
      TK_MINUS    = 4'd2,
      TK_TIMES    = 4'd3,
      TK_DIVIDE   = 4'd4,
      TK_OPEN     = 4'd5,
      TK_CLOSE    = 4'd6,
      TK_FUNCTION = 4'd7,
      TK_KW_E     = 4'd8,
      TK_KW_PI    = 4'd9,
      TK_END      = 4'd10,
      TK_ERROR    = 4'd11
   } tok_kind_type;

   typedef enum logic [2:0] {
      ER_NONE        = 3'd0,
      ER_BAD_FRAC    = 3'd1,
      ER_BAD_EXP     = 3'd2,
      ER_AFTER_NUM   = 3'd3,
      ER_AFTER_KW    = 3'd4,
      ER_AFTER_FUNC  = 3'd5,
      ER_BAD_CHAR    = 3'd6,
      ER_TOO_LONG    = 3'd7
   } err_code_type;

   typedef struct packed {
      tok_kind_type     kind;
      logic [POS_W-1:0] start;
      logic [LEN_W-1:0] len;
      err_code_type     err;
      logic             done;
      logic             last;
   } result_type;

   // One character's worth of results: one or two.
   typedef struct packed {
      result_type first;
      result_type second;
      logic       two;
   } job_type;

   // Builds a result; the length saturates at the field's maximum.
   function automatic result_type make_result(
      input tok_kind_type     kind,
      input logic [POS_W-1:0] start,
      input logic [LEN_W:0]   len,
      input err_code_type     err
   );
      result_type r;
      r.kind  = kind;
      r.start = start;
      r.len   = len[LEN_W] ? {LEN_W{1'b1}} : len[LEN_W-1:0];
      r.err   = err;
      r.done  = (kind == TK_END) || (kind == TK_ERROR);
      r.last  = 1'b0;
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== src/exlex_scan.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Expression lexer scanner
// Classifies each accepted character, steps the scan state machine and
// forms the one or two results that the character causes as one job.
// ----------------------------------------------------------------------------
module exlex_scan (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        accept,
   input  wire logic [exlex_pkg::CHAR_W-1:0] char_code,
   output exlex_pkg::job_type               job,
   output logic                             job_valid
);

   exlex_pkg::phase_type          phase_ff, phase_in;
   logic [exlex_pkg::POS_W-1:0]   start_ff, start_in;
   logic [exlex_pkg::LEN_W-1:0]   len_ff, len_in;
   logic [15:0]                   letters_ff, letters_in;
   logic [exlex_pkg::POS_W-1:0]   pos_ff, pos_in;

   // Character classes.
   logic                    c_nul, c_space, c_dig, c_low, c_op, c_follow;
   exlex_pkg::tok_kind_type c_op_kind;
   logic                    str_over, lex_over, kw_e, kw_pi;
   logic [exlex_pkg::LEN_W:0] len_inc;

   // Phase decisions.
   logic                    grow, pend, ph_fail, lex;
   exlex_pkg::phase_type    grow_ph;
   exlex_pkg::tok_kind_type pend_kind;
   exlex_pkg::err_code_type ph_err, a_err;
   logic                    a_fail, lex_end, lex_op, lex_bad, any_fail;

   exlex_pkg::result_type   res_a, res_b;
   logic                    a_v, b_v;

   always_comb begin
      c_nul     = (char_code == exlex_pkg::CH_NUL);
      c_space   = (char_code == exlex_pkg::CH_SPACE);
      c_dig     = (char_code >= exlex_pkg::CH_ZERO) && (char_code <= exlex_pkg::CH_NINE);
      c_low     = (char_code >= exlex_pkg::CH_LOW_A) && (char_code <= exlex_pkg::CH_LOW_Z);
      c_op      = 1'b1;
      c_op_kind = exlex_pkg::TK_NUMBER;
      unique case (char_code)
         exlex_pkg::CH_PLUS:  c_op_kind = exlex_pkg::TK_PLUS;
         exlex_pkg::CH_MINUS: c_op_kind = exlex_pkg::TK_MINUS;
         exlex_pkg::CH_STAR:  c_op_kind = exlex_pkg::TK_TIMES;
         exlex_pkg::CH_SLASH: c_op_kind = exlex_pkg::TK_DIVIDE;
         exlex_pkg::CH_OPEN:  c_op_kind = exlex_pkg::TK_OPEN;
         exlex_pkg::CH_CLOSE: c_op_kind = exlex_pkg::TK_CLOSE;
         default:             c_op      = 1'b0;
      endcase
      c_follow = c_space || c_nul || c_op;
      str_over = !c_nul && (32'(pos_ff) >= 32'(exlex_pkg::MAX_STRING_LEN));
      len_inc  = {1'b0, len_ff} + 1'b1;
      lex_over = 32'(len_inc) > 32'(exlex_pkg::MAX_LEXEME_LEN);
      kw_e     = (len_ff == 8'd1) && (letters_ff[15:8] == exlex_pkg::CH_LOW_E);
      kw_pi    = (len_ff == 8'd2) &&
                 (letters_ff == {exlex_pkg::CH_LOW_P, exlex_pkg::CH_LOW_I});
   end

   // What the current phase does with the character.
   always_comb begin
      grow      = 1'b0;
      grow_ph   = exlex_pkg::PH_IDLE;
      pend      = 1'b0;
      pend_kind = exlex_pkg::TK_NUMBER;
      ph_fail   = 1'b0;
      ph_err    = exlex_pkg::ER_NONE;
      lex       = 1'b0;
      if (phase_ff == exlex_pkg::PH_SKIP) begin
         ph_fail = 1'b0;
      end else if (str_over) begin
         ph_fail = 1'b1;
         ph_err  = exlex_pkg::ER_TOO_LONG;
      end else begin
         unique case (phase_ff)
            exlex_pkg::PH_INT, exlex_pkg::PH_FRAC, exlex_pkg::PH_EXP: begin
               priority if (c_dig) begin
                  grow    = 1'b1;
                  grow_ph = phase_ff;
               end else if (char_code == exlex_pkg::CH_DOT &&
                            phase_ff == exlex_pkg::PH_INT) begin
                  grow    = 1'b1;
                  grow_ph = exlex_pkg::PH_DOT;
               end else if (char_code == exlex_pkg::CH_EXP &&
                            phase_ff != exlex_pkg::PH_EXP) begin
                  grow    = 1'b1;
                  grow_ph = exlex_pkg::PH_EXPE;
               end else if (c_follow) begin
                  pend = 1'b1;
                  lex  = 1'b1;
               end else begin
                  ph_fail = 1'b1;
                  ph_err  = exlex_pkg::ER_AFTER_NUM;
               end
            end
            exlex_pkg::PH_DOT: begin
               if (c_dig) begin
                  grow    = 1'b1;
                  grow_ph = exlex_pkg::PH_FRAC;
               end else begin
                  ph_fail = 1'b1;
                  ph_err  = exlex_pkg::ER_BAD_FRAC;
               end
            end
            exlex_pkg::PH_EXPE: begin
               if (char_code == exlex_pkg::CH_PLUS || char_code == exlex_pkg::CH_MINUS) begin
                  grow    = 1'b1;
                  grow_ph = exlex_pkg::PH_EXPS;
               end else begin
                  ph_fail = 1'b1;
                  ph_err  = exlex_pkg::ER_BAD_EXP;
               end
            end
            exlex_pkg::PH_EXPS: begin
               if (c_dig) begin
                  grow    = 1'b1;
                  grow_ph = exlex_pkg::PH_EXP;
               end else begin
                  ph_fail = 1'b1;
                  ph_err  = exlex_pkg::ER_BAD_EXP;
               end
            end
            exlex_pkg::PH_WORD: begin
               priority if (c_low) begin
                  grow    = 1'b1;
                  grow_ph = exlex_pkg::PH_WORD;
               end else if (kw_e || kw_pi) begin
                  if (c_follow) begin
                     pend      = 1'b1;
                     pend_kind = kw_e ? exlex_pkg::TK_KW_E : exlex_pkg::TK_KW_PI;
                     lex       = 1'b1;
                  end else begin
                     ph_fail = 1'b1;
                     ph_err  = exlex_pkg::ER_AFTER_KW;
                  end
               end else if (char_code == exlex_pkg::CH_OPEN) begin
                  pend      = 1'b1;
                  pend_kind = exlex_pkg::TK_FUNCTION;
                  lex       = 1'b1;
               end else begin
                  ph_fail = 1'b1;
                  ph_err  = exlex_pkg::ER_AFTER_FUNC;
               end
            end
            exlex_pkg::PH_IDLE: lex = 1'b1;
            default:            lex = 1'b0;
         endcase
      end
      a_fail   = ph_fail || (grow && lex_over);
      a_err    = ph_fail ? ph_err : exlex_pkg::ER_TOO_LONG;
      lex_end  = lex && c_nul;
      lex_op   = lex && c_op;
      lex_bad  = lex && !c_nul && !c_op && !c_dig && !c_low && !c_space;
      any_fail = a_fail || lex_bad;
   end

   // Next state.
   always_comb begin
      phase_in   = phase_ff;
      start_in   = start_ff;
      len_in     = len_ff;
      letters_in = letters_ff;
      pos_in     = pos_ff;
      if (phase_ff == exlex_pkg::PH_SKIP) begin
         if (c_nul) begin
            phase_in = exlex_pkg::PH_IDLE;
            pos_in   = '0;
         end
      end else begin
         if (any_fail) begin
            phase_in   = c_nul ? exlex_pkg::PH_IDLE : exlex_pkg::PH_SKIP;
            len_in     = '0;
            letters_in = '0;
         end else if (grow) begin
            phase_in = grow_ph;
            len_in   = len_inc[exlex_pkg::LEN_W-1:0];
            if (phase_ff == exlex_pkg::PH_WORD && len_ff == 8'd1) begin
               letters_in[7:0] = char_code;
            end
         end else if (lex) begin
            phase_in   = exlex_pkg::PH_IDLE;
            len_in     = '0;
            letters_in = '0;
            if (c_dig) begin
               phase_in = exlex_pkg::PH_INT;
               start_in = pos_ff;
               len_in   = 8'd1;
            end else if (c_low) begin
               phase_in   = exlex_pkg::PH_WORD;
               start_in   = pos_ff;
               len_in     = 8'd1;
               letters_in = {char_code, 8'h00};
            end
         end
         if (!any_fail || c_nul) begin
            if (c_nul) begin
               phase_in   = exlex_pkg::PH_IDLE;
               len_in     = '0;
               letters_in = '0;
               pos_in     = '0;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
      end
   end

   // Results of this character.
   always_comb begin
      res_a = exlex_pkg::make_result(pend_kind, start_ff, {1'b0, len_ff}, exlex_pkg::ER_NONE);
      if (a_fail) begin
         if (str_over) begin
            res_a = exlex_pkg::make_result(exlex_pkg::TK_ERROR, pos_ff, 9'd1,
                                           exlex_pkg::ER_TOO_LONG);
         end else begin
            res_a = exlex_pkg::make_result(exlex_pkg::TK_ERROR, start_ff, len_inc, a_err);
         end
      end
      a_v = a_fail || pend;

      res_b = exlex_pkg::make_result(c_op_kind, pos_ff, 9'd1, exlex_pkg::ER_NONE);
      if (lex_end) begin
         res_b = exlex_pkg::make_result(exlex_pkg::TK_END, pos_ff, 9'd1, exlex_pkg::ER_NONE);
      end else if (lex_bad) begin
         res_b = exlex_pkg::make_result(exlex_pkg::TK_ERROR, pos_ff, 9'd1,
                                        exlex_pkg::ER_BAD_CHAR);
      end
      b_v = lex_end || lex_op || lex_bad;

      if (a_v) begin
         job.first  = res_a;
         job.second = res_b;
         job.two    = b_v;
      end else begin
         job.first  = res_b;
         job.second = res_b;
         job.two    = 1'b0;
      end
      if (job.two) begin
         job.second.last = 1'b1;
      end else begin
         job.first.last = 1'b1;
      end
      job_valid = accept && (a_v || b_v);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= exlex_pkg::PH_IDLE;
         start_ff   <= '0;
         len_ff     <= '0;
         letters_ff <= '0;
         pos_ff     <= '0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         start_ff   <= start_in;
         len_ff     <= len_in;
         letters_ff <= letters_in;
         pos_ff     <= pos_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/exlex_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Expression lexer job queue
// A short first-in first-out queue of jobs between scanner and output stage.
// ----------------------------------------------------------------------------
module exlex_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               wr_en,
   input  exlex_pkg::job_type      wr_job,
   output logic                    q_full,
   input  wire logic               rd_en,
   output exlex_pkg::job_type      rd_job,
   output logic                    q_empty
);

   exlex_pkg::job_type                slot_ff [exlex_pkg::QUEUE_DEPTH];
   logic [exlex_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [exlex_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [exlex_pkg::QPTR_W:0]        count_ff, count_in;

   always_comb begin
      q_full  = (count_ff == (exlex_pkg::QPTR_W+1)'(exlex_pkg::QUEUE_DEPTH));
      q_empty = (count_ff == '0);
      rd_job  = slot_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == exlex_pkg::QPTR_W'(exlex_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == exlex_pkg::QPTR_W'(exlex_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + {{exlex_pkg::QPTR_W{1'b0}}, wr_en}
                          - {{exlex_pkg::QPTR_W{1'b0}}, rd_en};
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/exlex_emit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Expression lexer output stage
// Takes jobs from the queue and hands their results out one beat at a time
// from an output register, with a second register for a job's second result.
// ----------------------------------------------------------------------------
module exlex_emit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_empty,
   input  exlex_pkg::job_type    q_job,
   output logic                  q_rd,
   output exlex_pkg::result_type out_res,
   output logic                  out_empty,
   input  wire logic             out_pop
);

   exlex_pkg::result_type out_ff, out_in;
   exlex_pkg::result_type second_ff, second_in;
   logic                  out_v_ff, out_v_in;
   logic                  second_v_ff, second_v_in;
   logic                  free;

   always_comb begin
      free        = !out_v_ff || out_pop;
      q_rd        = free && !second_v_ff && !q_empty;
      out_in      = out_ff;
      second_in   = second_ff;
      out_v_in    = out_v_ff && !out_pop;
      second_v_in = second_v_ff;
      if (free) begin
         if (second_v_ff) begin
            out_in      = second_ff;
            out_v_in    = 1'b1;
            second_v_in = 1'b0;
         end else if (!q_empty) begin
            out_in      = q_job.first;
            out_v_in    = 1'b1;
            second_in   = q_job.second;
            second_v_in = q_job.two;
         end
      end
      out_res   = out_ff;
      out_empty = !out_v_ff;
   end

   always_ff @(posedge clock) begin
      out_ff    <= out_in;
      second_ff <= second_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff    <= 1'b0;
         second_v_ff <= 1'b0;
      end else begin
         out_v_ff    <= out_v_in;
         second_v_ff <= second_v_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/expression_lexer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Expression lexer
// Character-serial lexer for arithmetic expressions with queue interfaces.
// ----------------------------------------------------------------------------
// The block takes one character per beat on the input queue (push/full) and
// returns tokens on the result queue (empty/pop), each with its start index
// and length. It accepts one character every clock cycle as long as the
// internal job queue has room. The first result of a character goes into the
// job queue and then into the output register before it shows on the result
// ports. A character can close a pending number or word and then be a token
// itself, so it may cause two results. The output stage hands out one result
// per cycle while results are popped, so a run of such characters fills the
// four-job queue, and full then follows the rate at which results are popped.
// The flag run_last marks the last result of each character, and string_done
// marks the end token and any error. After an error, characters up to the zero
// terminator are swallowed without results, and the next string starts again
// at index zero.
// ----------------------------------------------------------------------------
module expression_lexer (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // Input queue.
   input  wire logic                         push,
   output logic                              full,
   input  wire logic [exlex_pkg::CHAR_W-1:0] req_char_code,
   // Result queue.
   output logic                              empty,
   input  wire logic                         pop,
   output logic [3:0]                        rsp_token_kind,
   output logic [exlex_pkg::POS_W-1:0]       rsp_start_pos,
   output logic [exlex_pkg::LEN_W-1:0]       rsp_lexeme_len,
   output logic [2:0]                        rsp_error_code,
   output logic                              rsp_string_done,
   output logic                              rsp_run_last
);

   // A character is taken whenever the job queue can hold its results.
   logic                  accept;
   logic                  q_full, q_empty, q_rd, job_valid;
   exlex_pkg::job_type    job, q_job;
   exlex_pkg::result_type out_res;

   assign full   = q_full;
   assign accept = push && !q_full;

   // Front: classify the character and step the scan state machine.
   exlex_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .char_code (req_char_code),
      .job       (job),
      .job_valid (job_valid)
   );

   // Characters that only extend a lexeme, or spaces that close none, leave no job.
   exlex_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (job_valid),
      .wr_job  (job),
      .q_full  (q_full),
      .rd_en   (q_rd),
      .rd_job  (q_job),
      .q_empty (q_empty)
   );

   // Back: hand out results one beat at a time.
   exlex_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_job     (q_job),
      .q_rd      (q_rd),
      .out_res   (out_res),
      .out_empty (empty),
      .out_pop   (pop)
   );

   assign rsp_token_kind  = out_res.kind;
   assign rsp_start_pos   = out_res.start;
   assign rsp_lexeme_len  = out_res.len;
   assign rsp_error_code  = out_res.err;
   assign rsp_string_done = out_res.done;
   assign rsp_run_last    = out_res.last;

endmodule
`default_nettype wire

// ===== src/exlex_check.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Expression lexer port checker
// Watches the top-level ports and flags results that break the block's rules.
// ----------------------------------------------------------------------------
module exlex_check (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         full,
   input wire logic                         empty,
   input wire logic                         pop,
   input wire logic [3:0]                   rsp_token_kind,
   input wire logic [exlex_pkg::POS_W-1:0]  rsp_start_pos,
   input wire logic [exlex_pkg::LEN_W-1:0]  rsp_lexeme_len,
   input wire logic [2:0]                   rsp_error_code,
   input wire logic                         rsp_string_done,
   input wire logic                         rsp_run_last
);

   // Reset leaves both queues empty.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not empty after reset");

   // A waiting beat that is not taken stays as it is.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_token_kind) && $stable(rsp_start_pos)
                            && $stable(rsp_lexeme_len) && $stable(rsp_error_code)
                            && $stable(rsp_run_last)))
      else $error("stalled result changed");

   // The second result of a character follows right after the first.
   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      (!empty && pop && !rsp_run_last) |=> !empty)
      else $error("second result of a character not ready");

   // Error codes appear on error results only, and done marks end and error.
   a_codes: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (((rsp_token_kind == exlex_pkg::TK_ERROR) ==
                   (rsp_error_code != exlex_pkg::ER_NONE)) &&
                  (rsp_string_done == ((rsp_token_kind == exlex_pkg::TK_END) ||
                                       (rsp_token_kind == exlex_pkg::TK_ERROR)))))
      else $error("error code or done flag inconsistent with token kind");

   // Nothing follows the end of a string within the same character.
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_string_done) |-> rsp_run_last)
      else $error("done result is not the last of its character");

endmodule

bind expression_lexer exlex_check u_exlex_check (.*);
`default_nettype wire
